/* rtl/s256h_pkg.sv */
// ----------------------------------------------------------------------------
// s256h_pkg: shared types and constants for the streaming sha-256 hasher
// Round constants, initial hash values and the beat format used between the
// front (byte intake) and the back (compression and digest output).
// ----------------------------------------------------------------------------
package s256h_pkg;

	localparam int unsigned CmdQDepth = 4;

	// command beat from the front to the back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUNDS,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} back_state_t;

	localparam logic [31:0] HashInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* rtl/s256h_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// s256h_cmd_fifo: intake queue for input beats
// Small register queue that decouples the input side from the compression
// engine; it also drops beats that carry neither a byte nor an end mark.
// ----------------------------------------------------------------------------
module s256h_cmd_fifo #(
	parameter int unsigned DEPTH = s256h_pkg::CmdQDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  s256h_pkg::cmd_t   wr_cmd,
	output logic              full,
	input  logic              rd_pop,
	output logic              rd_valid,
	output s256h_pkg::cmd_t   rd_cmd
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	s256h_pkg::cmd_t  mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rp_q];
	// idle beats are accepted but never stored
	assign do_wr    = push && !full && (wr_cmd.has_byte || wr_cmd.last);
	assign do_rd    = rd_pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_cmd;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == '0) |-> !do_rd)
		else $error("pop of empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) full |=> !$past(do_wr))
		else $error("write while full");

endmodule

/* rtl/s256h_engine.sv */
// ----------------------------------------------------------------------------
// s256h_engine: block packing, padding, compression and digest output
// Packs bytes into the block buffer, runs one round per cycle, pads on the
// end mark and hands out the eight digest words through an output register.
// ----------------------------------------------------------------------------
module s256h_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  s256h_pkg::cmd_t   cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);

	s256h_pkg::back_state_t state_q, state_d;

	logic [31:0] chain_q [8];
	logic [31:0] blk_q   [16];
	logic [31:0] wv_q    [8];
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [5:0]  rnd_q;
	logic        fin_q;     // end of message pending after this block
	logic        lenblk_q;  // block being compressed holds the length
	logic        padded_q;  // 0x80 byte already placed for this message
	logic [2:0]  widx_q;
	logic        ovalid_q;
	logic [31:0] oword_q;
	logic [2:0]  oidx_q;

	// byte placement
	logic [3:0]  pb_word;
	logic [1:0]  pb_lane;
	logic [7:0]  pb_data;
	logic        put_en;
	logic [5:0]  fill_nx;
	logic        len_fits;

	// schedule word for this round, taken from the sliding window
	logic [31:0] w15, w2, s0, s1, wr, t1, t2, ch, mj, e1, a0;
	logic [31:0] wnew;
	assign w15  = blk_q[1];
	assign w2   = blk_q[14];
	assign s0   = s256h_pkg::rotr(w15, 7) ^ s256h_pkg::rotr(w15, 18) ^ (w15 >> 3);
	assign s1   = s256h_pkg::rotr(w2, 17) ^ s256h_pkg::rotr(w2, 19) ^ (w2 >> 10);
	assign wnew = blk_q[0] + s0 + blk_q[9] + s1;
	assign wr   = (rnd_q < 6'd16) ? blk_q[0] : wnew;
	assign e1   = s256h_pkg::rotr(wv_q[4], 6) ^ s256h_pkg::rotr(wv_q[4], 11)
	            ^ s256h_pkg::rotr(wv_q[4], 25);
	assign ch   = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign a0   = s256h_pkg::rotr(wv_q[0], 2) ^ s256h_pkg::rotr(wv_q[0], 13)
	            ^ s256h_pkg::rotr(wv_q[0], 22);
	assign mj   = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1   = wv_q[7] + e1 + ch + s256h_pkg::round_k(rnd_q) + wr;
	assign t2   = a0 + mj;

	// output register frees when taken
	logic out_free;
	assign out_free = !ovalid_q || pop;

	// control
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		put_en  = 1'b0;
		pb_data = cmd.data_byte;
		unique case (state_q)
			s256h_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					put_en  = cmd.has_byte;
					if (cmd.has_byte && fill_q == 6'd63) state_d = s256h_pkg::ST_ROUNDS;
					else if (cmd.last) state_d = s256h_pkg::ST_PAD;
				end
			end
			s256h_pkg::ST_ROUNDS: if (rnd_q == 6'd63) state_d = s256h_pkg::ST_FOLD;
			s256h_pkg::ST_FOLD: begin
				if (!fin_q) state_d = s256h_pkg::ST_IDLE;
				else if (lenblk_q) state_d = s256h_pkg::ST_EMIT;
				else state_d = s256h_pkg::ST_PAD;
			end
			s256h_pkg::ST_PAD:  state_d = s256h_pkg::ST_ROUNDS;
			s256h_pkg::ST_EMIT: if (out_free && widx_q == 3'd7) state_d = s256h_pkg::ST_IDLE;
			default:            state_d = s256h_pkg::ST_IDLE;
		endcase
	end

	assign pb_word = fill_q[5:2];
	assign pb_lane = fill_q[1:0];
	assign fill_nx = fill_q + 6'd1;
	// the length goes in this pad block: always on the second one, else when
	// the fill after the pad byte is 1..56
	assign len_fits = padded_q || ((fill_nx != 6'd0) && (fill_nx <= 6'd56));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= s256h_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			total_q  <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			lenblk_q <= 1'b0;
			padded_q <= 1'b0;
			widx_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 8; i++) chain_q[i] <= s256h_pkg::HashInit[i];
		end else begin
			if (state_q == s256h_pkg::ST_EMIT && out_free) ovalid_q <= 1'b1;
			else if (pop) ovalid_q <= 1'b0;
			unique case (state_q)
				s256h_pkg::ST_IDLE: if (cmd_valid) begin
					fin_q    <= cmd.last;
					lenblk_q <= 1'b0;
					rnd_q    <= '0;
					if (cmd.has_byte) begin
						fill_q  <= fill_nx;
						total_q <= total_q + 61'd1;
					end
				end
				s256h_pkg::ST_ROUNDS: rnd_q <= rnd_q + 6'd1;
				s256h_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
					widx_q <= '0;
				end
				s256h_pkg::ST_PAD: begin
					rnd_q    <= '0;
					// the 0x80 byte goes in only once per message
					if (!padded_q) fill_q <= fill_nx;
					lenblk_q <= len_fits;
					padded_q <= 1'b1;
				end
				s256h_pkg::ST_EMIT: if (out_free) begin
					widx_q <= widx_q + 3'd1;
					if (widx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) chain_q[i] <= s256h_pkg::HashInit[i];
						fill_q   <= '0;
						total_q  <= '0;
						padded_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// block buffer: byte packing, padding and schedule window shift
	always_ff @(posedge clk) begin
		if (put_en) begin
			case (pb_lane)
				2'd0: blk_q[pb_word] <= {pb_data, 24'h0};
				2'd1: blk_q[pb_word][23:16] <= pb_data;
				2'd2: blk_q[pb_word][15:8]  <= pb_data;
				default: blk_q[pb_word][7:0] <= pb_data;
			endcase
		end
		if (state_q == s256h_pkg::ST_PAD) begin
			for (int k = 0; k < 16; k++) begin
				if (len_fits && k == 14) begin
					blk_q[k] <= total_q[60:29];
				end else if (len_fits && k == 15) begin
					blk_q[k] <= {total_q[28:0], 3'b000};
				end else if (padded_q) begin
					blk_q[k] <= '0;
				end else if (4'(k) == pb_word) begin
					case (pb_lane)
						2'd0: blk_q[k] <= {s256h_pkg::PadByte, 24'h0};
						2'd1: blk_q[k] <= {blk_q[k][31:24], s256h_pkg::PadByte, 16'h0};
						2'd2: blk_q[k] <= {blk_q[k][31:16], s256h_pkg::PadByte, 8'h0};
						default: blk_q[k] <= {blk_q[k][31:8], s256h_pkg::PadByte};
					endcase
				end else if (4'(k) > pb_word) begin
					blk_q[k] <= '0;
				end
			end
		end
		if (state_q == s256h_pkg::ST_ROUNDS) begin
			for (int k = 0; k < 15; k++) blk_q[k] <= blk_q[k+1];
			blk_q[15] <= wr;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (state_d == s256h_pkg::ST_ROUNDS && state_q != s256h_pkg::ST_ROUNDS) begin
			for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
		end else if (state_q == s256h_pkg::ST_ROUNDS) begin
			for (int j = 7; j > 0; j--) begin
				if (j != 4) wv_q[j] <= wv_q[j-1];
			end
			wv_q[4] <= wv_q[3] + t1;
			wv_q[0] <= t1 + t2;
		end
	end

	// digest output register
	always_ff @(posedge clk) begin
		if (state_q == s256h_pkg::ST_EMIT && out_free) begin
			oword_q <= chain_q[widx_q];
			oidx_q  <= widx_q;
		end
	end

	assign empty       = !ovalid_q;
	assign digest_word = oword_q;
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s256h_pkg::ST_ROUNDS) |-> !cmd_pop)
		else $error("intake during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s256h_pkg::ST_FOLD) |-> $past(rnd_q) == 6'd63)
		else $error("fold before last round");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !pop) |=> $stable(oword_q))
		else $error("result changed while waiting");

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit: streaming sha-256 hasher
// Byte stream in, eight digest words out per message.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  input    | push / full    | data_byte, has_byte, last
//  result   | pop / empty    | digest_word, word_index, last_word
//
// the engine packs byte beats while idle; every 64th byte starts the 64
// one-per-cycle rounds and the fold into the chaining words.
// an end beat adds one or two padded blocks plus 8 words.
// the intake queue keeps taking up to four beats while the engine runs rounds.
// arst_n clears control and loads the initial hash values at once.
module sha256_stream_hasher_unit #(
	parameter int unsigned QDEPTH = s256h_pkg::CmdQDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	s256h_pkg::cmd_t wr_cmd, rd_cmd;
	logic            rd_valid, rd_pop;

	assign wr_cmd = '{data_byte: data_byte, has_byte: has_byte, last: last};

	s256h_cmd_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk, .arst_n, .push, .wr_cmd, .full,
		.rd_pop, .rd_valid, .rd_cmd
	);

	s256h_engine u_engine (
		.clk, .arst_n,
		.cmd_valid(rd_valid), .cmd(rd_cmd), .cmd_pop(rd_pop),
		.empty, .pop, .digest_word, .word_index, .last_word
	);

endmodule
